/* rtl/core/psg_pkg.sv */
// Shared types, opcodes and the attenuation table for the tone/noise generator.
// No dependencies; every module in rtl/core imports this package.
package psg_pkg;

   localparam int NUM_CH    = 4;
   localparam int NUM_TONE  = 3;
   localparam int PERIOD_W  = 10;
   localparam int VOL_W     = 4;
   localparam int SUM_W     = 18;
   localparam int SAMPLE_W  = 16;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_TICK  = 1'b1
   } psg_op_type;

   typedef logic [NUM_CH-1:0][PERIOD_W-1:0] period_arr_type;
   typedef logic [NUM_CH-1:0][VOL_W-1:0]    volume_arr_type;

   // One beat leaving the input stage: a register write or a sample tick
   typedef struct packed {
      logic       wr_en;
      logic       tick_en;
      logic [7:0] data;
   } psg_cmd_type;

   localparam logic [PERIOD_W-1:0] PERIOD_LO_MASK = 10'h00F;
   localparam logic [PERIOD_W-1:0] PERIOD_HI_MASK = 10'h3F0;
   localparam logic [15:0]         NOISE_SEED     = 16'h8000;

   // Attenuation table: roughly 2 dB per step, last step silent
   function automatic logic [14:0] level_lookup(input logic [VOL_W-1:0] vol);
      logic [14:0] v;
      case (vol)
         4'd0:    v = 15'd32767;
         4'd1:    v = 15'd26028;
         4'd2:    v = 15'd20675;
         4'd3:    v = 15'd16422;
         4'd4:    v = 15'd13045;
         4'd5:    v = 15'd10362;
         4'd6:    v = 15'd8231;
         4'd7:    v = 15'd6538;
         4'd8:    v = 15'd5193;
         4'd9:    v = 15'd4125;
         4'd10:   v = 15'd3276;
         4'd11:   v = 15'd2602;
         4'd12:   v = 15'd2067;
         4'd13:   v = 15'd1642;
         4'd14:   v = 15'd1304;
         default: v = 15'd0;
      endcase
      return v;
   endfunction

endpackage

/* rtl/core/psg_tone_noise_generator.sv */
// Tone/noise sound generator top: input stage, register file, generators, mixer.
// A tick's sample is registered in the result reg once the tick leaves the input stage; writes give none.
// Throughput: one beat per cycle, unless a tick waits in the input stage on a full, stalled result reg.
// Reset (synchronous, active high): periods, counts, volumes, levels, latch clear;
// LFSR loads 0x8000; both pipeline stages empty. Depends on psg_pkg and submodules.
module psg_tone_noise_generator import psg_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_opcode,
   input  logic [7:0]                 req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample
);

   // input stage
   logic       s1_valid_ff, s1_valid_in;
   psg_op_type s1_op_ff;
   logic [7:0] s1_data_ff;

   // result stage
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;

   logic                       req_accept;
   logic                       advance;
   logic                       s1_tick;
   psg_cmd_type                cmd;
   period_arr_type             period;
   volume_arr_type             volume;
   logic [NUM_CH-1:0]          level_next;
   logic signed [SAMPLE_W-1:0] mix_sample;

   assign s1_tick = (s1_op_ff == OP_TICK);

   // A write beat always retires; a tick retires when the result reg is free
   // or is being emptied in this cycle.
   assign advance    = s1_valid_ff && (!s1_tick || !rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign cmd.wr_en   = advance && !s1_tick;
   assign cmd.tick_en = advance && s1_tick;
   assign cmd.data    = s1_data_ff;

   psg_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .period (period),
      .volume (volume)
   );

   psg_gen u_gen (
      .clock      (clock),
      .reset      (reset),
      .tick_en    (cmd.tick_en),
      .period     (period),
      .level_next (level_next)
   );

   psg_mix u_mix (
      .volume (volume),
      .level  (level_next),
      .sample (mix_sample)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      if (cmd.tick_en) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = mix_sample;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff   <= psg_op_type'(req_opcode);
         s1_data_ff <= req_data;
      end
      rsp_sample_ff <= rsp_sample_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

   // Input stage only holds off when a tick waits on a full, stalled result reg
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s1_tick && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked tick");

   // A tick that retires must land in the result register
   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      cmd.tick_en |=> rsp_valid_ff)
      else $error("retired tick produced no result");

   // Write beats never wait
   a_write_flows: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_tick) |-> advance)
      else $error("write beat held in input stage");

   // Mixed samples stay inside the symmetric range
   a_sample_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_sample_ff != 16'sh8000))
      else $error("sample outside symmetric range");

endmodule

/* rtl/core/psg_regs.sv */
// Register file: latch index, channel periods and volumes, written by data bytes.
// Depends on psg_pkg.
module psg_regs import psg_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  psg_cmd_type    cmd,
   output period_arr_type period,
   output volume_arr_type volume
);

   logic [2:0]          latched_ff, latched_in;
   period_arr_type      period_ff, period_in;
   volume_arr_type      volume_ff, volume_in;
   logic [2:0]          sel;
   logic [1:0]          ch;
   logic [PERIOD_W-1:0] p;

   always_comb begin
      latched_in = latched_ff;
      period_in  = period_ff;
      volume_in  = volume_ff;
      sel        = cmd.data[7] ? cmd.data[6:4] : latched_ff;
      ch         = sel[2:1];
      p          = '0;
      if (cmd.wr_en) begin
         latched_in = sel;
         if (sel[0]) begin
            volume_in[ch] = cmd.data[3:0];
         end else begin
            if (cmd.data[7]) begin
               p = (period_ff[ch] & PERIOD_HI_MASK) | {6'd0, cmd.data[3:0]};
            end else begin
               p = (period_ff[ch] & PERIOD_LO_MASK) | {cmd.data[5:0], 4'd0};
            end
            // a zero period is forced to one
            if (p == '0) begin
               p = PERIOD_W'(1);
            end
            period_in[ch] = p;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latched_ff <= '0;
         period_ff  <= '0;
         volume_ff  <= '0;
      end else begin
         latched_ff <= latched_in;
         period_ff  <= period_in;
         volume_ff  <= volume_in;
      end
   end

   assign period = period_ff;
   assign volume = volume_ff;

endmodule

/* rtl/core/psg_gen.sv */
// Tone/noise generators: four period counters, three tone flip-flops and the LFSR.
// Depends on psg_pkg. Gives the channel levels as they stand after the current tick.
module psg_gen import psg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              tick_en,
   input  period_arr_type    period,
   output logic [NUM_CH-1:0] level_next
);

   period_arr_type        count_ff, count_in;
   logic [NUM_TONE-1:0]   tone_ff, tone_in;
   logic [15:0]           noise_shift_ff, noise_shift_in;
   logic                  noise_ff, noise_in;
   logic [NUM_CH-1:0]     hit;
   logic [PERIOD_W-1:0]   n;

   always_comb begin
      count_in       = count_ff;
      tone_in        = tone_ff;
      noise_shift_in = noise_shift_ff;
      noise_in       = noise_ff;
      hit            = '0;
      n              = '0;
      for (int c = 0; c < NUM_CH; c++) begin
         n      = count_ff[c] + PERIOD_W'(1);
         hit[c] = (n >= period[c]);
         if (tick_en) begin
            count_in[c] = hit[c] ? '0 : n;
         end
      end
      if (tick_en) begin
         for (int c = 0; c < NUM_TONE; c++) begin
            tone_in[c] = tone_ff[c] ^ hit[c];
         end
         if (hit[NUM_CH-1]) begin
            noise_shift_in = {noise_shift_ff[0] ^ noise_shift_ff[1], noise_shift_ff[15:1]};
            noise_in       = noise_shift_ff[0];
         end
      end
      level_next = {noise_in, tone_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         tone_ff        <= '0;
         noise_shift_ff <= NOISE_SEED;
         noise_ff       <= 1'b0;
      end else begin
         count_ff       <= count_in;
         tone_ff        <= tone_in;
         noise_shift_ff <= noise_shift_in;
         noise_ff       <= noise_in;
      end
   end

endmodule

/* rtl/core/psg_mix.sv */
// Mixer: signed sum of four table levels, divided by four toward zero.
// Depends on psg_pkg (level_lookup, widths). Purely combinational.
module psg_mix import psg_pkg::*; (
   input  volume_arr_type             volume,
   input  logic [NUM_CH-1:0]          level,
   output logic signed [SAMPLE_W-1:0] sample
);

   logic signed [SUM_W-1:0] term [NUM_CH];
   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] biased;

   always_comb begin
      sum = '0;
      for (int c = 0; c < NUM_CH; c++) begin
         term[c] = $signed({3'd0, level_lookup(volume[c])});
         if (!level[c]) begin
            term[c] = -term[c];
         end
         sum = sum + term[c];
      end
      // bias negatives by 3 so the arithmetic shift truncates toward zero
      biased = sum + (sum[SUM_W-1] ? SUM_W'(3) : SUM_W'(0));
      sample = SAMPLE_W'(biased >>> 2);
   end

endmodule
